@@ hdl/mpwm_pkg.sv @@
package mpwm_pkg;

  // Fixed-point formats: position and gain Q0.16, samples Q1.23, weights Q1.15.
  localparam int POS_W    = 17;
  localparam int SAMPLE_W = 24;
  localparam int MIXED_W  = 32;
  localparam int ACC_W    = 40;
  localparam int IDX_W    = 7;
  localparam int CFG_IDX_W = 2;

  // Default for the MAX_INPUTS parameter (1 to 127, bounded by IDX_W).
  localparam int MAX_INPUTS_DEF = 64;

  localparam logic [POS_W-1:0] ONE_Q16  = 17'd65536;
  localparam logic [POS_W-1:0] HALF_Q16 = 17'd32768;

  // Coefficients of the odd sine polynomial, angle in Q0.16 units of pi/2.
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [15:0] SIN_B = 16'd42048;
  localparam logic [15:0] SIN_C = 16'd4640;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd1;

  // Per-block state record held in the state memory.
  typedef struct packed {
    logic [POS_W-1:0]        pos;
    logic [IDX_W-1:0]        idx;
    logic signed [ACC_W-1:0] acc;
    logic [POS_W-1:0]        phase;
  } rec_t;

  localparam rec_t RESET_REC = '{pos: HALF_Q16, idx: '0, acc: '0, phase: '0};

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SM1,
    ST_SM2,
    ST_PHASE,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_W4,
    ST_TERM,
    ST_WB
  } state_t;

endpackage

@@ hdl/mpwm_state_ram.sv @@
module mpwm_state_ram (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic          wr_en,
  input  mpwm_pkg::rec_t wr_data,
  output mpwm_pkg::rec_t rd_data
);

  mpwm_pkg::rec_t state_mem_r [1];
  logic           valid_r;
  mpwm_pkg::rec_t rd_data_r;

  // Write port; the entry becomes valid on its first write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      state_mem_r[0] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r <= 1'b1;
    end
  end

  // Registered read; an entry never written reads as the reset record.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r ? state_mem_r[0] : mpwm_pkg::RESET_REC;
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/modal_position_weighted_mixer.sv @@
// Modal position weighted mixer.
// Input stream: one beat per input-channel sample, in_tdata[23:0] holds the
// signed Q1.23 sample and in_tlast marks the last channel of a frame. At the
// first beat of a frame the smoothed position steps toward target_position
// with gain smoothing_gain; sample k is weighted by sin(pi*(k+1)*position).
// Output stream: one beat per frame, on the tlast sample, carrying the
// weighted sum saturated to signed 32 bits in out_tdata.
// Configuration: cfg_wr_en with cfg_index 0 (target position) or 1
// (smoothing gain), Q0.16, values above 1.0 are stored as 1.0. Write only
// while the block is idle.
// Sequence: each accepted sample reads the state memory (LOAD), runs
// SM1 and SM2 at the first sample of a frame, then PHASE, W1 to W4 and TERM,
// and ends with a write-back (WB); samples past MAX_INPUTS go from LOAD to WB.
// One shared multiplier walks the sine polynomial and the sample product in
// turn. A new sample is taken only once the block is back in idle. The frame
// result is registered in the write-back step of its last sample.
// Reset: synchronous, active low; position returns to 0.5, gain to 1.0, and
// the frame state is cleared. If the receiver stalls, the result is held and
// the block keeps taking samples until it must deliver the next result.
module modal_position_weighted_mixer #(
  parameter int MAX_INPUTS = mpwm_pkg::MAX_INPUTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: sample[23:0]
  input  logic [23:0]                    in_tdata,
  input  logic                           in_tlast,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // out_tdata: mixed[31:0]
  output logic [31:0]                    out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_wr_en,
  input  logic [mpwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpwm_pkg::POS_W-1:0]     cfg_data
);

  localparam logic [mpwm_pkg::IDX_W-1:0] MAX_IDX = mpwm_pkg::IDX_W'(MAX_INPUTS);

  mpwm_pkg::state_t state_r, state_nxt;

  logic [mpwm_pkg::POS_W-1:0] tgt_pos_r, gain_r, cfg_clamped;

  // Working registers of the current sample.
  logic [mpwm_pkg::POS_W-1:0]        pos_r, phase_r;
  logic [mpwm_pkg::IDX_W-1:0]        idx_r;
  logic signed [mpwm_pkg::ACC_W-1:0] acc_r;
  logic signed [mpwm_pkg::SAMPLE_W-1:0] sample_r;
  logic                              last_r;
  logic [32:0]                       tmp_r;
  logic [16:0]                       z_r, z2_r;
  logic                              neg_r;
  logic [15:0]                       inner0_r, inner_r;
  logic signed [15:0]                w_r;

  logic [31:0] out_data_r;
  logic        out_valid_r;
  logic        out_busy;

  // State memory port.
  logic           ram_rd_en, ram_wr_en;
  mpwm_pkg::rec_t ram_wr_data, ram_rd_data;

  // Shared multiplier.
  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [42:0] mul_p;

  // Combinational helpers.
  logic [33:0]         sm_sum;
  logic [16:0]         phase_sum;
  logic [15:0]         rem;
  logic [16:0]         rem_fold;
  logic [16:0]         sin_diff;
  logic [15:0]         y_half;
  logic [14:0]         y_clamp;
  logic signed [42:0]  term_full;
  logic signed [mpwm_pkg::ACC_W-1:0] term_ext;
  logic [31:0]         sat_val;

  mpwm_state_ram u_state_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (ram_rd_en),
    .wr_en   (ram_wr_en),
    .wr_data (ram_wr_data),
    .rd_data (ram_rd_data)
  );

  // Configuration registers with clamping to 1.0.
  assign cfg_clamped = (cfg_data > mpwm_pkg::ONE_Q16) ? mpwm_pkg::ONE_Q16 : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_pos_r <= mpwm_pkg::HALF_Q16;
      gain_r    <= mpwm_pkg::ONE_Q16;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mpwm_pkg::CFG_TARGET: tgt_pos_r <= cfg_clamped;
        mpwm_pkg::CFG_GAIN:   gain_r    <= cfg_clamped;
        default: ;
      endcase
    end
  end

  assign out_busy = out_valid_r && !out_tready;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mpwm_pkg::ST_IDLE:  if (in_tvalid) state_nxt = mpwm_pkg::ST_LOAD;
      mpwm_pkg::ST_LOAD: begin
        if (ram_rd_data.idx == '0) begin
          state_nxt = mpwm_pkg::ST_SM1;
        end else if (ram_rd_data.idx < MAX_IDX) begin
          state_nxt = mpwm_pkg::ST_PHASE;
        end else begin
          state_nxt = mpwm_pkg::ST_WB;
        end
      end
      mpwm_pkg::ST_SM1:   state_nxt = mpwm_pkg::ST_SM2;
      mpwm_pkg::ST_SM2:   state_nxt = mpwm_pkg::ST_PHASE;
      mpwm_pkg::ST_PHASE: state_nxt = mpwm_pkg::ST_W1;
      mpwm_pkg::ST_W1:    state_nxt = mpwm_pkg::ST_W2;
      mpwm_pkg::ST_W2:    state_nxt = mpwm_pkg::ST_W3;
      mpwm_pkg::ST_W3:    state_nxt = mpwm_pkg::ST_W4;
      mpwm_pkg::ST_W4:    state_nxt = mpwm_pkg::ST_TERM;
      mpwm_pkg::ST_TERM:  state_nxt = mpwm_pkg::ST_WB;
      mpwm_pkg::ST_WB:    if (!(last_r && out_busy)) state_nxt = mpwm_pkg::ST_IDLE;
      default:            state_nxt = mpwm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpwm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer outputs: handshake, memory enables and multiplier operands.
  always_comb begin
    in_tready = 1'b0;
    ram_rd_en = 1'b0;
    ram_wr_en = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    sin_diff  = mpwm_pkg::SIN_A - {1'b0, inner_r};
    unique case (state_r)
      mpwm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        ram_rd_en = in_tvalid;
      end
      mpwm_pkg::ST_SM1: begin
        mul_a = {8'd0, gain_r};
        mul_b = {1'b0, tgt_pos_r};
      end
      mpwm_pkg::ST_SM2: begin
        mul_a = {8'd0, mpwm_pkg::ONE_Q16 - gain_r};
        mul_b = {1'b0, pos_r};
      end
      mpwm_pkg::ST_W1: begin
        mul_a = {8'd0, z_r};
        mul_b = {1'b0, z_r};
      end
      mpwm_pkg::ST_W2: begin
        mul_a = {8'd0, z2_r};
        mul_b = {2'b00, mpwm_pkg::SIN_C};
      end
      mpwm_pkg::ST_W3: begin
        mul_a = {8'd0, z2_r};
        mul_b = {2'b00, inner0_r};
      end
      mpwm_pkg::ST_W4: begin
        mul_a = {8'd0, z_r};
        mul_b = {1'b0, sin_diff};
      end
      mpwm_pkg::ST_TERM: begin
        mul_a = {sample_r[mpwm_pkg::SAMPLE_W-1], sample_r};
        mul_b = {{2{w_r[15]}}, w_r};
      end
      mpwm_pkg::ST_WB: begin
        ram_wr_en = !(last_r && out_busy);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Smoothing step: (a*t + (1-a)*s + 0.5) >> 16.
  assign sm_sum = {1'b0, tmp_r} + {1'b0, mul_p[32:0]} + 34'd32768;

  // Phase of the next harmonic, folded into a quarter period.
  assign phase_sum = phase_r + pos_r;
  assign rem       = phase_sum[15:0];
  assign rem_fold  = (rem > 16'd32768) ? (17'd65536 - {1'b0, rem}) : {1'b0, rem};

  // Sine result halved and clamped to Q1.15.
  assign y_half  = mul_p[32:17];
  assign y_clamp = (y_half > 16'd32767) ? 15'h7FFF : y_half[14:0];

  // Product rounded from Q.38 to Q.23, sign carried into the accumulator width.
  assign term_full = mul_p + 43'sd16384;
  assign term_ext  = mpwm_pkg::ACC_W'($signed(term_full[42:15]));

  // Saturate the sum to the signed 32-bit range.
  always_comb begin
    if (acc_r > 40'sd2147483647) begin
      sat_val = 32'h7FFF_FFFF;
    end else if (acc_r < -40'sd2147483648) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = acc_r[31:0];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      mpwm_pkg::ST_IDLE: begin
        sample_r <= in_tdata;
        last_r   <= in_tlast;
      end
      mpwm_pkg::ST_LOAD: begin
        pos_r   <= ram_rd_data.pos;
        idx_r   <= ram_rd_data.idx;
        acc_r   <= ram_rd_data.acc;
        phase_r <= ram_rd_data.phase;
      end
      mpwm_pkg::ST_SM1: tmp_r <= mul_p[32:0];
      mpwm_pkg::ST_SM2: begin
        pos_r   <= sm_sum[32:16];
        acc_r   <= '0;
        phase_r <= '0;
      end
      mpwm_pkg::ST_PHASE: begin
        phase_r <= phase_sum;
        neg_r   <= phase_sum[16];
        z_r     <= {rem_fold[15:0], 1'b0};
      end
      mpwm_pkg::ST_W1: z2_r     <= mul_p[32:16];
      mpwm_pkg::ST_W2: inner0_r <= mpwm_pkg::SIN_B - mul_p[31:16];
      mpwm_pkg::ST_W3: inner_r  <= mul_p[31:16];
      mpwm_pkg::ST_W4: w_r <= neg_r ? -$signed({1'b0, y_clamp}) : $signed({1'b0, y_clamp});
      mpwm_pkg::ST_TERM: begin
        acc_r <= acc_r + term_ext;
        idx_r <= idx_r + 1'b1;
      end
      default: ;
    endcase
  end

  // Write-back record: a flagged sample closes the frame.
  always_comb begin
    ram_wr_data.pos = pos_r;
    if (last_r) begin
      ram_wr_data.idx   = '0;
      ram_wr_data.acc   = '0;
      ram_wr_data.phase = '0;
    end else begin
      ram_wr_data.idx   = idx_r;
      ram_wr_data.acc   = acc_r;
      ram_wr_data.phase = phase_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == mpwm_pkg::ST_WB && last_r && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == mpwm_pkg::ST_WB && last_r && !out_busy) begin
      out_data_r <= sat_val;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A new result only appears from the write-back step of a flagged sample.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == mpwm_pkg::ST_WB) && $past(last_r))
    else $error("result raised outside write-back of a last sample");

  // An accepted sample always starts a state memory read.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == mpwm_pkg::ST_LOAD)
    else $error("accepted sample did not enter load");

  // The channel count never passes the configured limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mpwm_pkg::ST_WB |-> idx_r <= MAX_IDX)
    else $error("channel index beyond limit");

  // The smoothed position stays within 0 to 1.0.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mpwm_pkg::ST_PHASE |-> pos_r <= mpwm_pkg::ONE_Q16)
    else $error("smoothed position out of range");

  // A pending result is never overwritten while the receiver stalls.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result lost");

endmodule

@@ sim/mixer_checker.sv @@
module mixer_checker #(
  parameter int MAX_CH = mpwm_pkg::MAX_INPUTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: sample[23:0]
  input  logic [mpwm_pkg::SAMPLE_W-1:0]    in_tdata,
  input  logic                             in_tlast,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // out_tdata: mixed[31:0]
  input  logic [mpwm_pkg::MIXED_W-1:0]     out_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_wr_en,
  input  logic [mpwm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpwm_pkg::POS_W-1:0]       cfg_data,
  output int                               outstanding,
  output int                               fail_count
);

  // Q0.16 unity and the sine polynomial coefficients (angle in Q0.16 of pi/2).
  localparam logic [63:0] UNITY      = 64'd65536;
  localparam logic [63:0] POLY_LIN   = 64'd102944;
  localparam logic [63:0] POLY_CUBE  = 64'd42048;
  localparam logic [63:0] POLY_QUINT = 64'd4640;
  localparam longint      MIX_MAX    = 64'sd2147483647;
  localparam longint      MIX_MIN    = -64'sd2147483648;

  // Predicted block state and configuration.
  logic [mpwm_pkg::POS_W-1:0]   goal_pos;
  logic [mpwm_pkg::POS_W-1:0]   glide_gain;
  logic [mpwm_pkg::POS_W-1:0]   cur_pos;
  int unsigned                  chan;
  longint                       mix_sum;
  logic [mpwm_pkg::MIXED_W-1:0] mixed_due_q[$];

  // Register writes above 1.0 are stored as 1.0.
  function automatic logic [16:0] clamp_unity(logic [16:0] v);
    return (v > 17'd65536) ? 17'd65536 : v;
  endfunction

  // Q1.15 weight sin(pi * harmonic * pos) from the folded odd polynomial.
  function automatic longint sine_weight(int unsigned harmonic, logic [16:0] pos);
    logic [63:0] h, phase, r, z, z2, inner, y;
    h = harmonic;
    phase = (h * pos) & 64'h1FFFF;
    r = phase & 64'hFFFF;
    if (r > 64'd32768) r = UNITY - r;
    z = r << 1;
    z2 = (z * z) >> 16;
    inner = POLY_CUBE - ((z2 * POLY_QUINT) >> 16);
    inner = (z2 * inner) >> 16;
    y = (z * (POLY_LIN - inner)) >> 16;
    y = y >> 1;
    if (y > 64'd32767) y = 64'd32767;
    return phase[16] ? -longint'(y) : longint'(y);
  endfunction

  // Q1.23 sample times Q1.15 weight, rounded half up back to Q.23.
  function automatic longint sample_term(logic signed [23:0] smp, longint w);
    longint sv, prod;
    sv = smp;
    prod = sv * w;
    return (prod + 64'sd16384) >>> 15;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // Advance the prediction by one accepted input beat.
  task automatic take_sample(logic signed [23:0] smp, logic last);
    logic [63:0] blend;
    longint      sat;
    if (chan == 0) begin
      blend = glide_gain * goal_pos + (UNITY - glide_gain) * cur_pos + 64'd32768;
      cur_pos = blend[32:16];
      mix_sum = 0;
    end
    // Channels past the limit are dropped but the frame still runs on.
    if (chan < MAX_CH) begin
      mix_sum += sample_term(smp, sine_weight(chan + 1, cur_pos));
      chan++;
    end
    if (last) begin
      sat = mix_sum;
      if (sat > MIX_MAX) sat = MIX_MAX;
      if (sat < MIX_MIN) sat = MIX_MIN;
      mixed_due_q.push_back(sat[31:0]);
      chan = 0;
      mix_sum = 0;
    end
  endtask

  // Watch both channels and the register port on every rising edge.
  always @(posedge clk) begin
    logic [mpwm_pkg::MIXED_W-1:0] want;
    if (!rst_n) begin
      goal_pos   = mpwm_pkg::HALF_Q16;
      glide_gain = mpwm_pkg::ONE_Q16;
      cur_pos    = mpwm_pkg::HALF_Q16;
      chan       = 0;
      mix_sum    = 0;
      mixed_due_q.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == mpwm_pkg::CFG_TARGET) goal_pos = clamp_unity(cfg_data);
        else if (cfg_index == mpwm_pkg::CFG_GAIN) glide_gain = clamp_unity(cfg_data);
      end
      // A result beat is matched against the oldest predicted sum.
      if (out_tvalid && out_tready) begin
        if (mixed_due_q.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with no frame pending",
                                    $signed(out_tdata)));
        end else begin
          want = mixed_due_q.pop_front();
          if (out_tdata !== want)
            report_mismatch($sformatf("mixed %0d, predicted %0d",
                                      $signed(out_tdata), $signed(want)));
        end
      end
      if (in_tvalid && in_tready) take_sample(in_tdata, in_tlast);
    end
    outstanding <= mixed_due_q.size();
  end

endmodule

@@ sim/tb_top.sv @@
module tb_top;

  localparam int MAX_CH      = mpwm_pkg::MAX_INPUTS_DEF;
  localparam int SEG_BEATS   = 118;
  localparam int SETTLE      = 24;
  localparam int RUN_LIMIT   = 6000000;

  // Register indexes the block does not decode.
  localparam logic [mpwm_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [mpwm_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // in_tdata: sample[23:0]
  logic [mpwm_pkg::SAMPLE_W-1:0]  in_tdata   = '0;
  logic                           in_tlast   = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  // out_tdata: mixed[31:0]
  logic [mpwm_pkg::MIXED_W-1:0]   out_tdata;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic                           cfg_wr_en  = 1'b0;
  logic [mpwm_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [mpwm_pkg::POS_W-1:0]     cfg_data   = '0;

  int outstanding;
  int fail_count;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int beats_sent      = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  modal_position_weighted_mixer #(.MAX_INPUTS(MAX_CH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  mixer_checker #(.MAX_CH(MAX_CH)) u_mix_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Present one sample beat after a random gap and hold it until taken.
  task automatic send_sample(logic [23:0] smp, logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // Mostly full-range samples, with the two extremes now and then.
  function automatic logic [23:0] pick_sample();
    case ($urandom_range(9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_frame(int len);
    for (int k = 0; k < len; k++) send_sample(pick_sample(), k == len - 1);
  endtask

  // Short frames dominate; a few fill or overrun the channel limit.
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(8, 1);
    if (r < 95) return $urandom_range(MAX_CH, 9);
    return $urandom_range(MAX_CH + 8, MAX_CH + 1);
  endfunction

  // Stop sending and wait until every frame sum has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Reprogram both registers on an idle block, plus a write the block ignores.
  task automatic write_regs(logic [16:0] tgt, logic [16:0] gain);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= mpwm_pkg::CFG_TARGET;
    cfg_data  <= tgt;
    @(posedge clk);
    cfg_index <= mpwm_pkg::CFG_GAIN;
    cfg_data  <= gain;
    @(posedge clk);
    cfg_index <= $urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO;
    cfg_data  <= 17'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Register setting for a random segment; the first few are the corners.
  task automatic program_segment(int seg);
    logic [16:0] tgt, gain;
    case (seg)
      0: begin tgt = 17'd65536;  gain = 17'd65536;  end
      1: begin tgt = 17'd0;      gain = 17'd65536;  end
      2: begin tgt = 17'd50000;  gain = 17'd0;      end
      3: begin tgt = 17'd131071; gain = 17'd1;      end
      4: begin tgt = 17'd12000;  gain = 17'd4096;   end
      5: begin tgt = 17'd100000; gain = 17'd131071; end
      default: begin
        tgt  = 17'($urandom_range(3) == 0 ? $urandom : $urandom_range(65536));
        gain = 17'($urandom_range(3) == 0 ? $urandom : $urandom_range(65536));
      end
    endcase
    write_regs(tgt, gain);
  endtask

  initial begin
    int start;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames, first under the reset register values.
    send_sample(24'h7FFFFF, 1'b1);
    send_sample(24'h800000, 1'b0);
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'hFFFFFF, 1'b0);
    send_sample(24'h000000, 1'b1);
    // Both registers written above 1.0, so they hold 1.0.
    write_regs(17'd131071, 17'd131071);
    send_sample(24'h800000, 1'b0);
    send_sample(24'h800000, 1'b0);
    send_sample(24'h7FFFFF, 1'b1);
    // Position snaps to zero: every weight vanishes.
    write_regs(17'd0, 17'd65536);
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h800000, 1'b1);
    // Zero gain freezes the position whatever the target.
    write_regs(17'd20000, 17'd0);
    send_sample(24'h555555, 1'b0);
    send_sample(24'hAAAAAA, 1'b0);
    send_sample(24'h7FFFFF, 1'b1);
    write_regs(17'd65536, 17'd1);
    send_sample(24'h123456, 1'b0);
    send_sample(24'hEDCBA9, 1'b1);
    write_regs(17'd30000, 17'd65535);
    send_sample(24'h800000, 1'b0);
    send_sample(24'h000001, 1'b1);

    // Random frames under each idling pattern and several register settings.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin sender_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        program_segment(phase * 3 + seg);
        start = beats_sent;
        // Each phase opens with a frame that overruns the channel limit.
        if (seg == 0) send_frame(MAX_CH + $urandom_range(7, 1));
        while (beats_sent - start < SEG_BEATS) begin
          send_frame(pick_len());
          if ($urandom_range(99) < 3) drain();
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
